FILE: design/pfla_pkg.sv
// shared constants, codes and types for the page free list allocator
package pfla_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int IDX_W      = $clog2(NUM_PAGES);
  localparam int CNT_W      = $clog2(NUM_PAGES + 1);
  localparam int PG_W       = ADDR_W - PAGE_SHIFT;
  localparam int BASE_W     = PG_W + 1;
  localparam int FB_W       = 25;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] REGION_STOP_RST  = 32'h8100_0000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_STOP  = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef struct packed {
    logic load_req;
    logic commit;
  } pfla_cmd_t;

  typedef struct packed {
    logic out_full;
  } pfla_stat_t;

endpackage

FILE: design/pfla_req_if.sv
// request channel: operation and page address
interface pfla_req_if import pfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] page_address;

  modport source (output valid, output operation, output page_address, input ready);
  modport sink   (input valid, input operation, input page_address, output ready);
endinterface

FILE: design/pfla_rsp_if.sv
// result channel: status, granted address and free byte count
interface pfla_rsp_if import pfla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   granted_address;
  logic [FB_W-1:0]     free_bytes;

  modport source (output valid, output status, output granted_address, output free_bytes,
                  input ready);
  modport sink   (input valid, input status, input granted_address, input free_bytes,
                  output ready);
endinterface

FILE: design/pfla_ram.sv
// generic single write port ram with registered read
module pfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/pfla_ctrl.sv
// controller state machine: request intake and commit sequencing
module pfla_ctrl import pfla_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pfla_stat_t stat,
  output pfla_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.load_req = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.out_full) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: design/pfla_dp.sv
// datapath: region registers, free check, list head, counter, link store, result register
module pfla_dp import pfla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  input  logic                 req_operation,
  input  logic [ADDR_W-1:0]    req_page_address,
  input  pfla_cmd_t            cmd,
  output pfla_stat_t           stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [ADDR_W-1:0]    out_granted_address,
  output logic [FB_W-1:0]      out_free_bytes
);

  logic [ADDR_W-1:0]   region_start_r, region_stop_r;
  logic                op_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [IDX_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  logic [ADDR_W-1:0]   granted_r, granted_nxt;
  logic [FB_W-1:0]     fb_r;

  logic [BASE_W-1:0]   base_pg;
  logic [BASE_W-1:0]   addr_pg;
  logic [BASE_W-1:0]   pg_off;
  logic                free_ok;
  logic                push;
  logic [IDX_W-1:0]    link_rdata;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_start_r <= REGION_START_RST;
      region_stop_r  <= REGION_STOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REGION_START: region_start_r <= cfg_wdata;
        REG_REGION_STOP:  region_stop_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r   <= req_operation;
      addr_r <= req_page_address;
    end
  end

  // page base rounded up, in page units
  assign base_pg = {1'b0, region_start_r[ADDR_W-1:PAGE_SHIFT]}
                 + BASE_W'(|region_start_r[PAGE_SHIFT-1:0]);
  assign addr_pg = {1'b0, addr_r[ADDR_W-1:PAGE_SHIFT]};
  assign pg_off  = addr_pg - base_pg;

  assign free_ok = (addr_r[PAGE_SHIFT-1:0] == '0)
                && (addr_r >= region_start_r)
                && (addr_r < region_stop_r)
                && (addr_pg >= base_pg)
                && (pg_off < BASE_W'(NUM_PAGES))
                && (count_r < CNT_W'(NUM_PAGES));

  assign push = cmd.commit && (op_r == OP_FREE) && free_ok;

  pfla_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk   (clk),
    .we    (push),
    .waddr (pg_off[IDX_W-1:0]),
    .wdata (head_r),
    .raddr (head_r),
    .rdata (link_rdata)
  );

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    status_nxt  = ST_OK;
    granted_nxt = '0;
    if (op_r == OP_FREE) begin
      if (free_ok) begin
        head_nxt  = pg_off[IDX_W-1:0];
        count_nxt = count_r + CNT_W'(1);
      end else begin
        status_nxt = ST_BAD_FREE;
      end
    end else begin
      if (count_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        granted_nxt = {base_pg[PG_W-1:0] + PG_W'(head_r), {PAGE_SHIFT{1'b0}}};
        head_nxt    = link_rdata;
        count_nxt   = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.commit) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r  <= status_nxt;
      granted_r <= granted_nxt;
      fb_r      <= FB_W'({count_nxt, {PAGE_SHIFT{1'b0}}});
    end
  end

  assign stat.out_full       = out_valid_r && !out_ready;
  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_granted_address = granted_r;
  assign out_free_bytes      = fb_r;

endmodule

FILE: design/page_free_list_allocator.sv
// top level of the lifo page free list allocator
//
//   channel  dir  payload                                   handshake
//   in_req   in   operation, page_address                   valid/ready
//   out_rsp  out  status, granted_address, free_bytes       valid/ready
//   cfg      in   cfg_index, cfg_wdata                      cfg_we
//
// each request passes through intake, then check and commit; the check and commit step
// waits for the link store's registered read of the head entry.
// a new request is taken while the previous result waits in the output register;
// commit stalls only while that register is still full and not taken.
// rst_n is synchronous; the list is empty after reset, the link store is not cleared.
module page_free_list_allocator import pfla_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  pfla_req_if.sink             in_req,
  pfla_rsp_if.source           out_rsp
);

  pfla_cmd_t  cmd;
  pfla_stat_t stat;

  pfla_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfla_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .req_operation       (in_req.operation),
    .req_page_address    (in_req.page_address),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_rsp.valid),
    .out_ready           (out_rsp.ready),
    .out_status          (out_rsp.status),
    .out_granted_address (out_rsp.granted_address),
    .out_free_bytes      (out_rsp.free_bytes)
  );

endmodule

FILE: tb/tb.sv
// self-checking testbench for the lifo page free list allocator
module tb;
  import pfla_pkg::*;

  localparam int          IDLE_PCT      = 8;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LIMIT_TIME    = 4_000_000;
  localparam int          PAGE_BYTES    = 1 << PAGE_SHIFT;
  localparam logic [63:0] PAGE_MASK     = 64'(PAGE_BYTES - 1);
  localparam logic [63:0] FB_MAX        = (64'd1 << FB_W) - 1;

  typedef logic [IDX_W:0] link_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] granted;
    logic [FB_W-1:0]   free_bytes;
  } alloc_result_t;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    alloc_result_t     want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;

  pfla_req_if in_req ();
  pfla_rsp_if out_rsp ();

  page_free_list_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_rsp   (out_rsp)
  );

  // free list mirror
  link_t             free_link [NUM_PAGES];
  link_t             top_page;
  int                pages_listed;
  logic [ADDR_W-1:0] cur_start;
  logic [ADDR_W-1:0] cur_stop;

  alloc_result_t due_results [$];
  int            errors;
  bit            steady;
  bit            hold_req;

  dir_row_t dir_rows [22] = '{
    '{OP_ALLOC, 32'h0000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 25'd0}},
    '{OP_FREE,  32'h8000_0000, 1'b1, '{ST_OK,       32'h0000_0000, 25'd4096}},
    '{OP_FREE,  32'h80FF_F000, 1'b1, '{ST_OK,       32'h0000_0000, 25'd8192}},
    '{OP_FREE,  32'h8000_0800, 1'b1, '{ST_BAD_FREE, 32'h0000_0000, 25'd8192}},
    '{OP_FREE,  32'h8000_0001, 1'b1, '{ST_BAD_FREE, 32'h0000_0000, 25'd8192}},
    '{OP_FREE,  32'h7FFF_F000, 1'b1, '{ST_BAD_FREE, 32'h0000_0000, 25'd8192}},
    '{OP_FREE,  32'h8100_0000, 1'b1, '{ST_BAD_FREE, 32'h0000_0000, 25'd8192}},
    '{OP_FREE,  32'hFFFF_FFFF, 1'b1, '{ST_BAD_FREE, 32'h0000_0000, 25'd8192}},
    '{OP_FREE,  32'h0000_0000, 1'b1, '{ST_BAD_FREE, 32'h0000_0000, 25'd8192}},
    '{OP_ALLOC, 32'hFFFF_FFFF, 1'b1, '{ST_OK,       32'h80FF_F000, 25'd4096}},
    // double free goes back on the list
    '{OP_FREE,  32'h8000_0000, 1'b1, '{ST_OK,       32'h0000_0000, 25'd8192}},
    '{OP_ALLOC, 32'h0000_0000, 1'b1, '{ST_OK,       32'h8000_0000, 25'd4096}},
    '{OP_ALLOC, 32'h0000_0000, 1'b1, '{ST_OK,       32'h8000_0000, 25'd0}},
    '{OP_ALLOC, 32'h0000_0000, 1'b1, '{ST_EMPTY,    32'h0000_0000, 25'd0}},
    '{OP_FREE,  32'h8000_1000, 1'b0, '0},
    '{OP_FREE,  32'h8055_5000, 1'b0, '0},
    '{OP_FREE,  32'h80AA_A000, 1'b0, '0},
    '{OP_ALLOC, 32'h5555_5555, 1'b0, '0},
    '{OP_FREE,  32'h8000_1000, 1'b0, '0},
    '{OP_ALLOC, 32'hAAAA_AAAA, 1'b0, '0},
    '{OP_ALLOC, 32'h0000_0000, 1'b0, '0},
    '{OP_ALLOC, 32'h0000_0000, 1'b0, '0}
  };

  function automatic logic [63:0] page_base();
    return (64'(cur_start) + PAGE_MASK) & ~PAGE_MASK;
  endfunction

  function automatic alloc_result_t apply_request(input logic op,
                                                  input logic [ADDR_W-1:0] addr);
    alloc_result_t res;
    logic [63:0]   base;
    logic [63:0]   pg;
    logic [63:0]   bytes;
    res  = '{ST_OK, '0, '0};
    base = page_base();
    if (op == OP_FREE) begin
      pg = (64'(addr) - base) >> PAGE_SHIFT;
      if (addr[PAGE_SHIFT-1:0] == '0 && addr >= cur_start && addr < cur_stop &&
          64'(addr) >= base && pg < NUM_PAGES && pages_listed < NUM_PAGES) begin
        free_link[pg[IDX_W-1:0]] = top_page;
        top_page = link_t'(pg);
        pages_listed++;
      end else begin
        res.status = ST_BAD_FREE;
      end
    end else if (pages_listed == 0) begin
      res.status = ST_EMPTY;
    end else begin
      pg = 64'(top_page) % NUM_PAGES;
      res.granted = ADDR_W'(base + (pg << PAGE_SHIFT));
      top_page = free_link[pg[IDX_W-1:0]];
      pages_listed--;
    end
    bytes = 64'(pages_listed) << PAGE_SHIFT;
    res.free_bytes = (bytes > FB_MAX) ? FB_MAX[FB_W-1:0] : bytes[FB_W-1:0];
    return res;
  endfunction

  // aligned address inside the current region and store, when there is one
  function automatic logic [ADDR_W-1:0] listable_addr();
    logic [63:0] base;
    logic [63:0] span;
    int          idx;
    base = page_base();
    span = (64'(cur_stop) > base) ? ((64'(cur_stop) - base + PAGE_MASK) >> PAGE_SHIFT) : 64'd0;
    if (span > NUM_PAGES) span = NUM_PAGES;
    if (span == 0) return $urandom();
    idx = $urandom_range(0, int'(span) - 1);
    if (span > 4 && $urandom_range(0, 3) == 0) idx = $urandom_range(0, 3);
    return ADDR_W'(base + (64'(idx) << PAGE_SHIFT));
  endfunction

  function automatic logic [ADDR_W-1:0] any_addr();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return listable_addr() | ADDR_W'($urandom_range(1, PAGE_BYTES - 1));
      2: begin
        case ($urandom_range(0, 5))
          0: return cur_start;
          1: return cur_start - 1;
          2: return cur_stop;
          3: return cur_stop - PAGE_BYTES;
          4: return ADDR_W'(page_base() + (64'(NUM_PAGES) << PAGE_SHIFT));
          default: return ADDR_W'(page_base() + (64'(NUM_PAGES - 1) << PAGE_SHIFT));
        endcase
      end
      default: return listable_addr();
    endcase
  endfunction

  // called just after a falling edge; leaves valid high for a following request
  task automatic put_req(input logic op, input logic [ADDR_W-1:0] addr,
                         input bit typed = 1'b0, input alloc_result_t typed_res = '0);
    alloc_result_t res;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid        <= 1'b1;
    in_req.operation    <= op;
    in_req.page_address <= addr;
    do @(posedge clk); while (!in_req.ready);
    res = apply_request(op, addr);
    due_results.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_req.valid <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
  endtask

  task automatic program_region(input logic [ADDR_W-1:0] start_addr,
                                input logic [ADDR_W-1:0] stop_addr);
    wait_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REGION_START;
    cfg_wdata <= start_addr;
    @(negedge clk);
    cfg_index <= REG_REGION_STOP;
    cfg_wdata <= stop_addr;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_start = start_addr;
    cur_stop  = stop_addr;
  endtask

  task automatic random_phase(input int n_items, input bit hold_mid, input bit pause_mid);
    int bias;
    bias = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) bias = $urandom_range(25, 75);
      if (hold_mid && i == n_items / 2) hold_req = 1'b1;
      if (pause_mid && i == n_items / 2) wait_drain();
      if ($urandom_range(0, 99) < bias) put_req(OP_FREE, any_addr());
      else put_req(OP_ALLOC, $urandom());
    end
    // leave pages listed across the next region change
    repeat (16) put_req(OP_FREE, listable_addr());
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_TIME);
    $display("Verification failed");
    $finish;
  end

  initial begin : result_sink
    out_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_rsp.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d granted_address %h free_bytes %0d",
               out_rsp.status, out_rsp.granted_address, out_rsp.free_bytes);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp.status);
          errors++;
        end
        if (out_rsp.granted_address !== want.granted) begin
          $error("granted_address: expected %h, got %h", want.granted,
                 out_rsp.granted_address);
          errors++;
        end
        if (out_rsp.free_bytes !== want.free_bytes) begin
          $error("free_bytes: expected %0d, got %0d", want.free_bytes, out_rsp.free_bytes);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_REGION_START;
    cfg_wdata           = '0;
    in_req.valid        = 1'b0;
    in_req.operation    = OP_ALLOC;
    in_req.page_address = '0;
    cur_start           = REGION_START_RST;
    cur_stop            = REGION_STOP_RST;
    top_page            = '0;
    pages_listed        = 0;
    errors              = 0;
    steady              = 1'b0;
    hold_req            = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      put_req(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].want);

    steady = 1'b1;
    program_region(32'h0000_0000, 32'hFFFF_FFFF);
    random_phase(200, 1'b0, 1'b0);
    steady = 1'b0;

    program_region(32'h0001_2345, 32'h00A0_0000);
    random_phase(200, 1'b1, 1'b0);

    // base past the top of the address space, every free rejected
    program_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(200, 1'b0, 1'b0);

    program_region(32'h9000_0000, 32'h8000_0000);
    random_phase(200, 1'b0, 1'b1);

    program_region(32'hFFFF_F000, 32'hFFFF_FFFF);
    random_phase(200, 1'b0, 1'b0);

    program_region(32'h0000_0000, 32'h0000_0000);
    random_phase(200, 1'b1, 1'b0);

    // list a batch of pages, then empty the list and go past empty
    program_region(REGION_START_RST, REGION_STOP_RST);
    repeat (64) put_req(OP_FREE, listable_addr());
    while (pages_listed > 0) put_req(OP_ALLOC, $urandom());
    repeat (3) put_req(OP_ALLOC, $urandom());

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/pfla_pkg.sv
design/pfla_req_if.sv
design/pfla_rsp_if.sv
design/pfla_ram.sv
design/pfla_ctrl.sv
design/pfla_dp.sv
design/page_free_list_allocator.sv
tb/tb.sv
